FILE: hdl/assert_macros.svh
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Types and codes of the I2C register transfer sequencer.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  localparam logic [1:0] OP_POLL  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_LOAD  = 2'd3;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START      = 4'd1;
  localparam logic [3:0] PH_ADDR_W     = 4'd2;
  localparam logic [3:0] PH_REG        = 4'd3;
  localparam logic [3:0] PH_WRITE_DATA = 4'd4;
  localparam logic [3:0] PH_RESTART    = 4'd5;
  localparam logic [3:0] PH_ADDR_R     = 4'd6;
  localparam logic [3:0] PH_READ_DATA  = 4'd7;
  localparam logic [3:0] PH_DONE       = 4'd8;
  localparam logic [3:0] PH_ERROR      = 4'd9;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_BUSY     = 3'd1;
  localparam logic [2:0] ST_DONE     = 3'd2;
  localparam logic [2:0] ST_FAULT    = 3'd3;
  localparam logic [2:0] ST_ACCEPTED = 3'd4;
  localparam logic [2:0] ST_REJECTED = 3'd5;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RECV = 2'd2;

  localparam logic [1:0] ACK_KEEP    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  localparam int FL_SB   = 0;
  localparam int FL_ADDR = 1;
  localparam int FL_TXE  = 2;
  localparam int FL_BTF  = 3;
  localparam int FL_RXNE = 4;
  localparam int FL_NACK = 5;

  localparam logic [7:0] TIMEOUT_RESET = 8'd5;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [5:0] byte_count;
    logic [4:0] load_index;
    logic [7:0] byte_value;
    logic [5:0] status_flags;
    logic [15:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]  status_code;
    logic [1:0]  data_action;
    logic [7:0]  data_byte;
    logic [4:0]  data_index;
    logic        issue_start;
    logic        issue_stop;
    logic [1:0]  ack_control;
    logic        clear_nack;
    logic        read_status_two;
    logic        recover_bus;
    logic [15:0] fault_total;
    logic [15:0] recovery_total;
  } result_t;

  // Buffer port request: one write and one read position per cycle.
  typedef struct packed {
    logic       we;
    logic [4:0] widx;
    logic [7:0] wdata;
    logic [5:0] rpos;
  } bufreq_t;

endpackage

FILE: hdl/i2c_master_transfer_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_core
// Register read/write sequencer for a byte-level I2C master.
//
//   channel  direction  ports                      payload
//   in_      slave      tvalid tready tdata tuser  poll / start / load item
//   out_     master     tvalid tready tdata tuser  one result per item
//   cfg_     write      wr_en wr_data              phase timeout in ms
//
// One item per cycle unless stalled; results show in the cycle after.
// The transmit buffer is read ahead, registered, at the next send position.
// Reset is synchronous; the buffer content is not cleared.
// A stalled output holds its result; input is taken when the output
// register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core
  import i2cseq_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] device_address, [14:7] register_address, [20:15] byte_count,
  // [25:21] load_index, [33:26] byte_value, [39:34] status_flags,
  // [55:40] now_ms
  input  logic [55:0] in_tdata,
  // [1:0] op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status_code, [10:3] data_byte, [15:11] data_index,
  // [16] issue_start, [17] issue_stop, [19:18] ack_control,
  // [20] clear_nack, [21] read_status_two, [22] recover_bus,
  // [38:23] fault_total, [54:39] recovery_total, [55] zero
  output logic [55:0] out_tdata,
  // [1:0] data_action
  output logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  item_t      item;
  result_t    res;
  bufreq_t    breq;
  logic [7:0] buf_byte;
  logic       in_fire;

  logic        out_valid_r;
  logic [55:0] out_data_r;
  logic [1:0]  out_user_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    item.op               = in_tuser;
    item.device_address   = in_tdata[6:0];
    item.register_address = in_tdata[14:7];
    item.byte_count       = in_tdata[20:15];
    item.load_index       = in_tdata[25:21];
    item.byte_value       = in_tdata[33:26];
    item.status_flags     = in_tdata[39:34];
    item.now_ms           = in_tdata[55:40];
  end

  i2cseq_txbuf #(
    .DEPTH(BUFFER_DEPTH)
  ) u_txbuf (
    .clk    (clk),
    .req    (breq),
    .rd_byte(buf_byte)
  );

  i2cseq_ctrl #(
    .DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .item    (item),
    .cfg_we  (cfg_wr_en),
    .cfg_data(cfg_wr_data),
    .buf_byte(buf_byte),
    .breq    (breq),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {1'b0, res.recovery_total, res.fault_total, res.recover_bus,
                     res.read_status_two, res.clear_nack, res.ack_control,
                     res.issue_stop, res.issue_start, res.data_index,
                     res.data_byte, res.status_code};
      out_user_r <= res.data_action;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: hdl/i2cseq_txbuf.sv
// ----------------------------------------------------------------------------
// i2cseq_txbuf
// Transmit byte buffer; registered read of the next send position with
// write-to-read forwarding; an out-of-range position reads as zero.
// ----------------------------------------------------------------------------
module i2cseq_txbuf
  import i2cseq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  bufreq_t    req,
  output logic [7:0] rd_byte
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (AW > 6) ? AW : 6;
  localparam int LW = (AW > 5) ? AW : 5;
  localparam logic [8:0] DEPTH9 = 9'(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_byte_r;

  logic [PW-1:0] rpos_ext;
  logic [LW-1:0] widx_ext;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          w_ok;
  logic          r_ok;

  assign rpos_ext = PW'(req.rpos);
  assign widx_ext = LW'(req.widx);
  assign raddr    = rpos_ext[AW-1:0];
  assign waddr    = widx_ext[AW-1:0];
  assign w_ok     = req.we && ({4'b0000, req.widx} < DEPTH9);
  assign r_ok     = {3'b000, req.rpos} < DEPTH9;

  always_ff @(posedge clk) begin
    if (w_ok) begin
      mem[waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!r_ok) begin
      rd_byte_r <= 8'd0;
    end else if (w_ok && (waddr == raddr)) begin
      rd_byte_r <= req.wdata;
    end else begin
      rd_byte_r <= mem[raddr];
    end
  end

  assign rd_byte = rd_byte_r;

endmodule

FILE: hdl/i2cseq_ctrl.sv
// ----------------------------------------------------------------------------
// i2cseq_ctrl
// Transfer phase sequencer: decides one result per item and updates the
// transfer state, counters and timeout register.
// ----------------------------------------------------------------------------
module i2cseq_ctrl
  import i2cseq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  item_t      item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic [7:0] buf_byte,
  output bufreq_t    breq,
  output result_t    res
);

  localparam logic [8:0] DEPTH9 = 9'(DEPTH);

  logic [7:0]  timeout_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [6:0]  taddr_r, taddr_nxt;
  logic [7:0]  treg_r, treg_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        rd_r, rd_nxt;
  logic [15:0] tstart_r, tstart_nxt;
  logic [15:0] fault_r, fault_nxt;
  logic [15:0] recov_r, recov_nxt;

  logic        busy;
  logic        busy_nxt;
  logic        handled;
  logic        start_op;
  logic [15:0] elapsed;
  logic [5:0]  pos_inc;

  assign busy = (phase_r != PH_IDLE) && (phase_r != PH_DONE) && (phase_r != PH_ERROR);
  assign busy_nxt = (phase_nxt != PH_IDLE) && (phase_nxt != PH_DONE) &&
                    (phase_nxt != PH_ERROR);
  assign start_op = (item.op == OP_READ) || (item.op == OP_WRITE);
  assign elapsed  = item.now_ms - tstart_r;
  assign pos_inc  = pos_r + 6'd1;

  always_comb begin
    phase_nxt  = phase_r;
    taddr_nxt  = taddr_r;
    treg_nxt   = treg_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    rd_nxt     = rd_r;
    tstart_nxt = tstart_r;
    fault_nxt  = fault_r;
    recov_nxt  = recov_r;
    handled    = 1'b0;
    res        = '0;

    if (start_op) begin
      handled = 1'b1;
      if (busy || ({3'b000, item.byte_count} > DEPTH9) ||
          ((item.op == OP_READ) && (item.byte_count == 6'd0))) begin
        res.status_code = ST_REJECTED;
      end else begin
        taddr_nxt  = item.device_address;
        treg_nxt   = item.register_address;
        len_nxt    = item.byte_count;
        pos_nxt    = 6'd0;
        rd_nxt     = (item.op == OP_READ);
        phase_nxt  = PH_START;
        tstart_nxt = item.now_ms;
        res.status_code = ST_ACCEPTED;
      end
    end else if (item.op == OP_LOAD) begin
      handled = 1'b1;
      res.status_code = busy ? ST_BUSY : ST_IDLE;
    end else if (item.status_flags[FL_NACK]) begin
      handled = 1'b1;
      res.clear_nack  = 1'b1;
      res.issue_stop  = 1'b1;
      phase_nxt       = PH_ERROR;
      fault_nxt       = (fault_r != CNT_MAX) ? fault_r + 16'd1 : CNT_MAX;
      res.status_code = ST_FAULT;
    end else if (busy && (elapsed > {8'd0, timeout_r})) begin
      handled = 1'b1;
      res.recover_bus = 1'b1;
      recov_nxt       = (recov_r != CNT_MAX) ? recov_r + 16'd1 : CNT_MAX;
      phase_nxt       = PH_ERROR;
      fault_nxt       = (fault_r != CNT_MAX) ? fault_r + 16'd1 : CNT_MAX;
      res.status_code = ST_FAULT;
    end

    if (!handled) begin
      case (phase_r)
        PH_IDLE: begin
        end
        PH_START: begin
          res.ack_control = ACK_ENABLE;
          res.issue_start = 1'b1;
          phase_nxt       = PH_ADDR_W;
          tstart_nxt      = item.now_ms;
        end
        PH_ADDR_W: begin
          if (item.status_flags[FL_SB]) begin
            res.data_action = ACT_WRITE;
            res.data_byte   = {taddr_r, 1'b0};
            phase_nxt       = PH_REG;
            tstart_nxt      = item.now_ms;
          end
        end
        PH_REG: begin
          if (item.status_flags[FL_ADDR]) begin
            res.read_status_two = 1'b1;
            res.data_action     = ACT_WRITE;
            res.data_byte       = treg_r;
            phase_nxt           = rd_r ? PH_RESTART : PH_WRITE_DATA;
            tstart_nxt          = item.now_ms;
          end
        end
        PH_WRITE_DATA: begin
          if (item.status_flags[FL_TXE]) begin
            if (pos_r < len_r) begin
              res.data_action = ACT_WRITE;
              res.data_byte   = buf_byte;
              pos_nxt         = pos_inc;
              tstart_nxt      = item.now_ms;
            end else if (item.status_flags[FL_BTF]) begin
              res.issue_stop = 1'b1;
              phase_nxt      = PH_DONE;
            end
          end
        end
        PH_RESTART: begin
          if (item.status_flags[FL_BTF]) begin
            res.issue_start = 1'b1;
            phase_nxt       = PH_ADDR_R;
            tstart_nxt      = item.now_ms;
          end
        end
        PH_ADDR_R: begin
          if (item.status_flags[FL_SB]) begin
            res.data_action = ACT_WRITE;
            res.data_byte   = {taddr_r, 1'b1};
            if (len_r == 6'd1) begin
              res.ack_control = ACK_DISABLE;
            end
            phase_nxt  = PH_READ_DATA;
            tstart_nxt = item.now_ms;
          end
        end
        PH_READ_DATA: begin
          if (item.status_flags[FL_ADDR]) begin
            res.read_status_two = 1'b1;
            if (len_r == 6'd1) begin
              res.issue_stop = 1'b1;
            end
            tstart_nxt = item.now_ms;
          end else if (item.status_flags[FL_RXNE]) begin
            res.data_action = ACT_RECV;
            res.data_byte   = item.byte_value;
            res.data_index  = pos_r[4:0];
            pos_nxt         = pos_inc;
            tstart_nxt      = item.now_ms;
            if ((len_r != 6'd0) && (pos_inc == len_r - 6'd1)) begin
              res.ack_control = ACK_DISABLE;
              res.issue_stop  = 1'b1;
            end
            if (pos_inc >= len_r) begin
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_DONE: begin
          phase_nxt       = PH_IDLE;
          res.status_code = ST_DONE;
          handled         = 1'b1;
        end
        PH_ERROR: begin
          phase_nxt       = PH_IDLE;
          res.status_code = ST_FAULT;
          handled         = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      if (!handled) begin
        res.status_code = busy_nxt ? ST_BUSY : ST_IDLE;
      end
    end

    res.fault_total    = fault_nxt;
    res.recovery_total = recov_nxt;
  end

  always_comb begin
    breq.we    = fire && (item.op == OP_LOAD);
    breq.widx  = item.load_index;
    breq.wdata = item.byte_value;
    breq.rpos  = fire ? pos_nxt : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      taddr_r  <= '0;
      treg_r   <= '0;
      len_r    <= '0;
      pos_r    <= '0;
      rd_r     <= 1'b0;
      tstart_r <= '0;
      fault_r  <= '0;
      recov_r  <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      taddr_r  <= taddr_nxt;
      treg_r   <= treg_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      rd_r     <= rd_nxt;
      tstart_r <= tstart_nxt;
      fault_r  <= fault_nxt;
      recov_r  <= recov_nxt;
    end
  end

endmodule

FILE: hdl/i2cseq_checker.sv
// ----------------------------------------------------------------------------
// i2cseq_checker
// Port-level checks of the I2C register transfer sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cseq_checker
  import i2cseq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser),
    "stalled result changed")
  `ASSERT_CLK(a_code_range, clk, rst_n,
    out_tvalid |-> out_tdata[2:0] <= ST_REJECTED && out_tuser != 2'd3,
    "bad status or action code")
  `ASSERT_CLK(a_recover_err, clk, rst_n,
    out_tvalid && out_tdata[22] |-> out_tdata[2:0] == ST_FAULT && out_tdata[38:23] != 16'd0,
    "recovery without error")
  `ASSERT_CLK(a_nack_stop, clk, rst_n,
    out_tvalid && out_tdata[20] |-> out_tdata[17] && out_tdata[2:0] == ST_FAULT,
    "nack clear without stop")

endmodule

bind i2c_master_transfer_sequencer_core i2cseq_checker u_i2cseq_checker (.*);
